// ----- src/kmtv_pkg.sv -----
// Package for the k-mer extension tally vote block.
// Holds the tally width, the item and result types, the action and extension codes
// and the configuration register map. It depends on nothing else.
package kmtv_pkg;

    localparam int TALLY_BITS = 16;
    localparam int NUM_BASES = 4;
    localparam int FIELD_BITS = 16;
    localparam int KEEP_BITS = 17;
    localparam int SUM_BITS = ((TALLY_BITS > FIELD_BITS) ? TALLY_BITS : FIELD_BITS) + 1;
    localparam int CMP_BITS = (TALLY_BITS > KEEP_BITS) ? TALLY_BITS : KEEP_BITS;
    localparam int PROD_BITS = KEEP_BITS + FIELD_BITS;

    localparam int S_TDATA_BITS = 88;
    localparam int M_TDATA_BITS = 72;
    localparam int ADDR_BITS = 3;
    localparam int PDATA_BITS = 32;

    typedef logic [TALLY_BITS-1:0] tally_t;
    typedef tally_t [NUM_BASES-1:0] tally_vec_t;
    typedef logic [SUM_BITS-1:0] sum_t;
    typedef logic [CMP_BITS-1:0] cmp_t;
    typedef logic [FIELD_BITS-1:0] field_t;
    typedef logic [KEEP_BITS-1:0] keep_t;

    localparam tally_t TALLY_MAX = '1;

    typedef enum logic [1:0] {
        ACT_LOAD     = 2'd0,
        ACT_ADD_ONE  = 2'd1,
        ACT_ADD_FOUR = 2'd2,
        ACT_DECIDE   = 2'd3
    } action_t;

    typedef enum logic [2:0] {
        EXT_A    = 3'd0,
        EXT_C    = 3'd1,
        EXT_G    = 3'd2,
        EXT_T    = 3'd3,
        EXT_NONE = 3'd4,
        EXT_FORK = 3'd5
    } ext_t;

    localparam logic REG_MIN_DEPTH_FLOOR = 1'b0;
    localparam logic REG_KEEP_FRACTION = 1'b1;
    localparam field_t MIN_DEPTH_FLOOR_RESET = 16'd2;
    localparam keep_t KEEP_FRACTION_RESET = 17'd6554;

    typedef struct packed {
        field_t min_depth_floor;
        keep_t  keep_fraction_q16;
    } cfg_t;

    typedef struct packed {
        action_t action;
        logic [2:0] base;
        field_t amount;
        field_t [NUM_BASES-1:0] values;
    } item_t;

    typedef struct packed {
        ext_t extension;
        logic all_zero;
        field_t [NUM_BASES-1:0] tallies;
    } result_t;

endpackage

// ----- src/kmtv_cfg_regs.sv -----
// Configuration registers of the k-mer extension tally vote block, behind an APB port.
// Depends on kmtv_pkg for the register map and reset values.
module kmtv_cfg_regs (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [kmtv_pkg::ADDR_BITS-1:0]     paddr,
    input  logic [kmtv_pkg::PDATA_BITS-1:0]    pwdata,
    output logic [kmtv_pkg::PDATA_BITS-1:0]    prdata,
    output logic                               pready,
    output kmtv_pkg::cfg_t                     cfg
);

    kmtv_pkg::cfg_t cfg_reg;
    logic wr_en;
    logic reg_idx;

    assign pready = 1'b1;
    assign wr_en = psel & penable & pwrite & pready;
    assign reg_idx = paddr[2];
    assign cfg = cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.min_depth_floor <= kmtv_pkg::MIN_DEPTH_FLOOR_RESET;
            cfg_reg.keep_fraction_q16 <= kmtv_pkg::KEEP_FRACTION_RESET;
        end else if (wr_en) begin
            case (reg_idx)
                kmtv_pkg::REG_MIN_DEPTH_FLOOR: begin
                    cfg_reg.min_depth_floor <= pwdata[kmtv_pkg::FIELD_BITS-1:0];
                end
                kmtv_pkg::REG_KEEP_FRACTION: begin
                    cfg_reg.keep_fraction_q16 <= pwdata[kmtv_pkg::KEEP_BITS-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            kmtv_pkg::REG_MIN_DEPTH_FLOOR: prdata = kmtv_pkg::PDATA_BITS'(cfg_reg.min_depth_floor);
            kmtv_pkg::REG_KEEP_FRACTION: prdata = kmtv_pkg::PDATA_BITS'(cfg_reg.keep_fraction_q16);
            default: prdata = '0;
        endcase
    end

endmodule

// ----- src/kmtv_tally_update.sv -----
// Next-state logic for the four base tallies: load, saturating add to one base,
// or saturating add to all four; a decide leaves them as they are. Depends on kmtv_pkg.
module kmtv_tally_update (
    input  kmtv_pkg::item_t      item,
    input  kmtv_pkg::tally_vec_t tallies,
    output kmtv_pkg::tally_vec_t tallies_next
);

    function automatic kmtv_pkg::tally_t sat_add(kmtv_pkg::tally_t a, kmtv_pkg::field_t b);
        kmtv_pkg::sum_t s;
        s = kmtv_pkg::sum_t'(a) + kmtv_pkg::sum_t'(b);
        if (s > kmtv_pkg::sum_t'(kmtv_pkg::TALLY_MAX)) begin
            return kmtv_pkg::TALLY_MAX;
        end
        return kmtv_pkg::tally_t'(s);
    endfunction

    always_comb begin
        tallies_next = tallies;
        case (item.action)
            kmtv_pkg::ACT_LOAD: begin
                for (int i = 0; i < kmtv_pkg::NUM_BASES; i++) begin
                    tallies_next[i] = kmtv_pkg::tally_t'(item.values[i]);
                end
            end
            kmtv_pkg::ACT_ADD_ONE: begin
                if (!item.base[2]) begin
                    tallies_next[item.base[1:0]] =
                        sat_add(tallies[item.base[1:0]], item.amount);
                end
            end
            kmtv_pkg::ACT_ADD_FOUR: begin
                for (int i = 0; i < kmtv_pkg::NUM_BASES; i++) begin
                    tallies_next[i] = sat_add(tallies[i], item.values[i]);
                end
            end
            kmtv_pkg::ACT_DECIDE: begin
                tallies_next = tallies;
            end
            default: begin
                tallies_next = tallies;
            end
        endcase
    end

endmodule

// ----- src/kmtv_decide.sv -----
// Extension decision: ranks the four tallies, forms the dynamic minimum depth
// and answers a base, none or fork. Depends on kmtv_pkg.
module kmtv_decide (
    input  kmtv_pkg::tally_vec_t tallies,
    input  kmtv_pkg::field_t     kmer_count,
    input  kmtv_pkg::cfg_t       cfg,
    output kmtv_pkg::ext_t       extension
);

    logic [1:0] top_idx;
    kmtv_pkg::tally_t top_val;
    kmtv_pkg::tally_t second_val;
    logic have_second;
    logic [kmtv_pkg::PROD_BITS-1:0] product;
    kmtv_pkg::keep_t scaled;
    kmtv_pkg::keep_t dmin;

    always_comb begin
        top_idx = 2'd0;
        top_val = tallies[0];
        for (int i = 1; i < kmtv_pkg::NUM_BASES; i++) begin
            if (tallies[i] >= top_val) begin
                top_val = tallies[i];
                top_idx = 2'(i);
            end
        end
        second_val = '0;
        have_second = 1'b0;
        for (int i = 0; i < kmtv_pkg::NUM_BASES; i++) begin
            if (2'(i) != top_idx && (!have_second || tallies[i] > second_val)) begin
                second_val = tallies[i];
                have_second = 1'b1;
            end
        end
    end

    assign product = kmtv_pkg::PROD_BITS'(cfg.keep_fraction_q16)
                   * kmtv_pkg::PROD_BITS'(kmer_count);
    assign scaled = product[kmtv_pkg::PROD_BITS-1:kmtv_pkg::FIELD_BITS];
    assign dmin = (scaled < kmtv_pkg::keep_t'(cfg.min_depth_floor))
                ? kmtv_pkg::keep_t'(cfg.min_depth_floor) : scaled;

    always_comb begin
        if (kmtv_pkg::cmp_t'(top_val) < kmtv_pkg::cmp_t'(dmin)) begin
            extension = kmtv_pkg::EXT_NONE;
        end else if (kmtv_pkg::cmp_t'(second_val) >= kmtv_pkg::cmp_t'(dmin)) begin
            extension = kmtv_pkg::EXT_FORK;
        end else begin
            extension = kmtv_pkg::ext_t'({1'b0, top_idx});
        end
    end

endmodule

// ----- src/kmer_extension_tally_vote_top.sv -----
// Top level of the k-mer extension tally vote block: input register, tally state,
// result register and configuration port. Depends on kmtv_pkg, kmtv_cfg_regs,
// kmtv_tally_update and kmtv_decide.
//
// Items arrive on the s_ stream: tuser carries the action, tdata the base, the
// amount and four values. Every item yields exactly one result item on the m_
// stream, showing the decided extension (none for anything but a decide), an
// all-zero flag and the four tallies after the item.
// An accepted item waits in the input register; when it advances, it updates the
// tallies and loads the result register, so a result passes through the input
// register and the result register. The tally update, the ranking and the single
// 17 by 16 multiplier of the dynamic minimum all lie combinationally between those
// two registers, so one item is taken in every cycle while the result side keeps up.
// When the receiver stalls, the result register holds its item and the input
// register can still take one more item; after that s_tready falls until the
// result is taken. Reset clears both valid flags, zeroes the tallies and loads
// the configuration registers with their reset values. The user must write
// configuration registers over APB only while no item is in flight; the block does not enforce it.
module kmer_extension_tally_vote_top (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    // [2:0] base, [18:3] amount, [34:19] value_a, [50:35] value_c,
    // [66:51] value_g, [82:67] value_t, [87:83] zero
    input  logic [kmtv_pkg::S_TDATA_BITS-1:0]    s_tdata,
    // [1:0] action
    input  logic [1:0]                           s_tuser,
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    // [2:0] extension, [3] all_zero, [19:4] tally_a, [35:20] tally_c,
    // [51:36] tally_g, [67:52] tally_t, [71:68] zero
    output logic [kmtv_pkg::M_TDATA_BITS-1:0]    m_tdata,
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [kmtv_pkg::ADDR_BITS-1:0]       paddr,
    input  logic [kmtv_pkg::PDATA_BITS-1:0]      pwdata,
    output logic [kmtv_pkg::PDATA_BITS-1:0]      prdata,
    output logic                                 pready
);

    kmtv_pkg::cfg_t cfg;
    kmtv_pkg::item_t s_item;
    kmtv_pkg::item_t in_item_reg;
    logic in_valid_reg;
    logic out_valid_reg;
    kmtv_pkg::result_t res_reg;
    kmtv_pkg::result_t res_next;
    kmtv_pkg::tally_vec_t tally_reg;
    kmtv_pkg::tally_vec_t tally_next;
    kmtv_pkg::ext_t decided;
    logic advance;

    kmtv_cfg_regs u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    always_comb begin
        s_item.action = kmtv_pkg::action_t'(s_tuser[1:0]);
        s_item.base = s_tdata[2:0];
        s_item.amount = s_tdata[18:3];
        s_item.values[0] = s_tdata[34:19];
        s_item.values[1] = s_tdata[50:35];
        s_item.values[2] = s_tdata[66:51];
        s_item.values[3] = s_tdata[82:67];
    end

    assign advance = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    kmtv_tally_update u_update (
        .item         (in_item_reg),
        .tallies      (tally_reg),
        .tallies_next (tally_next)
    );

    kmtv_decide u_decide (
        .tallies    (tally_reg),
        .kmer_count (in_item_reg.amount),
        .cfg        (cfg),
        .extension  (decided)
    );

    always_comb begin
        res_next.extension = (in_item_reg.action == kmtv_pkg::ACT_DECIDE)
                           ? decided : kmtv_pkg::EXT_NONE;
        res_next.all_zero = (tally_next == '0);
        for (int i = 0; i < kmtv_pkg::NUM_BASES; i++) begin
            res_next.tallies[i] = kmtv_pkg::field_t'(tally_next[i]);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
            tally_reg <= '0;
        end else begin
            if (s_tvalid && s_tready) begin
                in_valid_reg <= 1'b1;
            end else if (advance) begin
                in_valid_reg <= 1'b0;
            end
            if (advance) begin
                out_valid_reg <= 1'b1;
                tally_reg <= tally_next;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_item_reg <= s_item;
        end
        if (advance) begin
            res_reg <= res_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata = {4'b0000,
                      res_reg.tallies[3], res_reg.tallies[2],
                      res_reg.tallies[1], res_reg.tallies[0],
                      res_reg.all_zero, res_reg.extension};

    a_reset_clears_output: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    a_full_stall_blocks_input: assert property (@(posedge aclk) disable iff (!aresetn)
        in_valid_reg && out_valid_reg && !m_tready |-> !s_tready)
        else $error("input taken while both stages are full");

    a_advance_gives_result: assert property (@(posedge aclk) disable iff (!aresetn)
        advance |=> m_tvalid)
        else $error("processed item produced no result");

    a_all_zero_matches_state: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (res_reg.all_zero == (tally_reg == '0)))
        else $error("all_zero flag disagrees with tally state");

endmodule

// ----- tb/sv/kmer_extension_tally_vote_top_tb.sv -----
// Self-checking testbench for the k-mer extension tally vote block.
// It predicts every result from its own tally model and checks the m_ stream
// against it, with random idling on both streams. It depends on kmtv_pkg and the RTL.
module kmer_extension_tally_vote_top_tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int STALL_LIMIT = 5000;
    localparam int HOLD_OFF_CYCLES = 300;

    logic                              aclk = 1'b0;
    logic                              aresetn;
    logic                              s_tvalid;
    logic                              s_tready;
    logic [kmtv_pkg::S_TDATA_BITS-1:0] s_tdata;
    logic [1:0]                        s_tuser;
    logic                              m_tvalid;
    logic                              m_tready;
    logic [kmtv_pkg::M_TDATA_BITS-1:0] m_tdata;
    logic                              psel;
    logic                              penable;
    logic                              pwrite;
    logic [kmtv_pkg::ADDR_BITS-1:0]    paddr;
    logic [kmtv_pkg::PDATA_BITS-1:0]   pwdata;
    logic [kmtv_pkg::PDATA_BITS-1:0]   prdata;
    logic                              pready;

    kmtv_pkg::tally_t  tally_model [kmtv_pkg::NUM_BASES];
    kmtv_pkg::field_t  floor_model;
    kmtv_pkg::keep_t   keep_model;
    kmtv_pkg::result_t pending_results [$];

    int  fail_count = 0;
    int  idle_cycles = 0;
    int  hold_off_request = 0;
    bit  sender_gaps = 1'b0;
    bit  receiver_gaps = 1'b0;

    kmer_extension_tally_vote_top u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always #1 aclk = ~aclk;

    function automatic kmtv_pkg::tally_t saturating_add(kmtv_pkg::tally_t tally,
                                                        kmtv_pkg::field_t amount);
        logic [kmtv_pkg::TALLY_BITS:0] sum;
        sum = {1'b0, tally} + amount;
        return sum[kmtv_pkg::TALLY_BITS] ? kmtv_pkg::TALLY_MAX
                                         : sum[kmtv_pkg::TALLY_BITS-1:0];
    endfunction

    function automatic kmtv_pkg::ext_t vote_extension(kmtv_pkg::field_t kmer_count);
        int                  top;
        kmtv_pkg::tally_t    top_val;
        kmtv_pkg::tally_t    runner_up;
        bit                  have_runner_up;
        logic [32:0]         product;
        logic [16:0]         dyn_min;
        top = 0;
        top_val = tally_model[0];
        have_runner_up = 1'b0;
        runner_up = '0;
        for (int i = 1; i < kmtv_pkg::NUM_BASES; i++) begin
            if (tally_model[i] >= top_val) begin
                top_val = tally_model[i];
                top = i;
            end
        end
        for (int i = 0; i < kmtv_pkg::NUM_BASES; i++) begin
            if (i != top && (!have_runner_up || tally_model[i] > runner_up)) begin
                runner_up = tally_model[i];
                have_runner_up = 1'b1;
            end
        end
        product = 33'(keep_model) * 33'(kmer_count);
        dyn_min = product[32:16];
        if (dyn_min < {1'b0, floor_model}) dyn_min = {1'b0, floor_model};
        if ({1'b0, top_val} < dyn_min) return kmtv_pkg::EXT_NONE;
        if ({1'b0, runner_up} >= dyn_min) return kmtv_pkg::EXT_FORK;
        return kmtv_pkg::ext_t'(top);
    endfunction

    function automatic kmtv_pkg::result_t apply_item(kmtv_pkg::item_t it);
        kmtv_pkg::result_t res;
        res.extension = kmtv_pkg::EXT_NONE;
        case (it.action)
            kmtv_pkg::ACT_LOAD: begin
                for (int i = 0; i < kmtv_pkg::NUM_BASES; i++) tally_model[i] = it.values[i];
            end
            kmtv_pkg::ACT_ADD_ONE: begin
                if (it.base < kmtv_pkg::NUM_BASES)
                    tally_model[it.base[1:0]] = saturating_add(tally_model[it.base[1:0]],
                                                               it.amount);
            end
            kmtv_pkg::ACT_ADD_FOUR: begin
                for (int i = 0; i < kmtv_pkg::NUM_BASES; i++)
                    tally_model[i] = saturating_add(tally_model[i], it.values[i]);
            end
            default: begin
                res.extension = vote_extension(it.amount);
            end
        endcase
        res.all_zero = (tally_model[0] | tally_model[1] | tally_model[2] | tally_model[3]) == '0;
        for (int i = 0; i < kmtv_pkg::NUM_BASES; i++) res.tallies[i] = tally_model[i];
        return res;
    endfunction

    function automatic kmtv_pkg::item_t make_item(kmtv_pkg::action_t act, logic [2:0] base,
                                                  kmtv_pkg::field_t amount,
                                                  kmtv_pkg::field_t va, kmtv_pkg::field_t vc,
                                                  kmtv_pkg::field_t vg, kmtv_pkg::field_t vt);
        kmtv_pkg::item_t it;
        it.action = act;
        it.base = base;
        it.amount = amount;
        it.values = {vt, vg, vc, va};
        return it;
    endfunction

    function automatic kmtv_pkg::field_t random_field();
        case ($urandom_range(0, 7))
            0: return '0;
            1: return '1;
            2: return kmtv_pkg::field_t'($urandom_range(0, 15));
            3: return kmtv_pkg::field_t'($urandom_range(0, 255));
            4: return kmtv_pkg::field_t'($urandom_range(65000, 65535));
            default: return kmtv_pkg::field_t'($urandom);
        endcase
    endfunction

    task automatic send_item(kmtv_pkg::item_t it);
        kmtv_pkg::result_t predicted;
        if (sender_gaps && $urandom_range(0, 9) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= it.action;
        s_tdata <= {5'b0, it.values[3], it.values[2], it.values[1], it.values[0],
                    it.amount, it.base};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        predicted = apply_item(it);
        pending_results = {pending_results, predicted};
    endtask

    task automatic wait_for_results();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending_results.size() != 0) @(posedge aclk);
    endtask

    task automatic settle_block();
        wait_for_results();
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_register(logic idx, logic [kmtv_pkg::PDATA_BITS-1:0] value);
        logic [kmtv_pkg::PDATA_BITS-1:0] expected;
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= kmtv_pkg::ADDR_BITS'({idx, 2'b00});
        pwdata <= value;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        if (idx == kmtv_pkg::REG_MIN_DEPTH_FLOOR) begin
            floor_model = value[kmtv_pkg::FIELD_BITS-1:0];
            expected = kmtv_pkg::PDATA_BITS'(floor_model);
        end else begin
            keep_model = value[kmtv_pkg::KEEP_BITS-1:0];
            expected = kmtv_pkg::PDATA_BITS'(keep_model);
        end
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        if (prdata !== expected) begin
            $error("register %0d read back: expected %0h, actual %0h", idx, expected, prdata);
            fail_count++;
        end
        psel <= 1'b0;
        penable <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic configure(kmtv_pkg::field_t min_floor, kmtv_pkg::keep_t keep_fraction);
        settle_block();
        write_register(kmtv_pkg::REG_MIN_DEPTH_FLOOR, kmtv_pkg::PDATA_BITS'(min_floor));
        write_register(kmtv_pkg::REG_KEEP_FRACTION, kmtv_pkg::PDATA_BITS'(keep_fraction));
    endtask

    task automatic send_vote_group();
        int n_adds;
        if ($urandom_range(0, 2) != 0)
            send_item(make_item(kmtv_pkg::ACT_LOAD, 3'($urandom), random_field(),
                                random_field(), random_field(), random_field(),
                                random_field()));
        n_adds = $urandom_range(0, 4);
        for (int i = 0; i < n_adds; i++) begin
            if ($urandom_range(0, 2) != 0)
                send_item(make_item(kmtv_pkg::ACT_ADD_ONE,
                                    ($urandom_range(0, 7) == 0) ? 3'($urandom_range(4, 7))
                                                                : 3'($urandom_range(0, 3)),
                                    random_field(), kmtv_pkg::field_t'($urandom),
                                    kmtv_pkg::field_t'($urandom),
                                    kmtv_pkg::field_t'($urandom),
                                    kmtv_pkg::field_t'($urandom)));
            else
                send_item(make_item(kmtv_pkg::ACT_ADD_FOUR, 3'($urandom),
                                    kmtv_pkg::field_t'($urandom),
                                    random_field(), random_field(), random_field(),
                                    random_field()));
        end
        send_item(make_item(kmtv_pkg::ACT_DECIDE, 3'($urandom), random_field(),
                            kmtv_pkg::field_t'($urandom), kmtv_pkg::field_t'($urandom),
                            kmtv_pkg::field_t'($urandom), kmtv_pkg::field_t'($urandom)));
    endtask

    task automatic send_noise();
        repeat ($urandom_range(1, 3))
            send_item(make_item(kmtv_pkg::action_t'($urandom_range(0, 3)), 3'($urandom),
                                kmtv_pkg::field_t'($urandom), kmtv_pkg::field_t'($urandom),
                                kmtv_pkg::field_t'($urandom), kmtv_pkg::field_t'($urandom),
                                kmtv_pkg::field_t'($urandom)));
    endtask

    task automatic test_directed_actions();
        send_item(make_item(kmtv_pkg::ACT_DECIDE, 3'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0));
        send_item(make_item(kmtv_pkg::ACT_LOAD, 3'd0, 16'd0, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                            16'hFFFF));
        send_item(make_item(kmtv_pkg::ACT_DECIDE, 3'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0));
        send_item(make_item(kmtv_pkg::ACT_ADD_ONE, 3'd0, 16'd1, 16'd0, 16'd0, 16'd0, 16'd0));
        send_item(make_item(kmtv_pkg::ACT_ADD_FOUR, 3'd0, 16'd0, 16'hFFFF, 16'd1, 16'hFFFF,
                            16'd7));
        send_item(make_item(kmtv_pkg::ACT_LOAD, 3'd7, 16'hFFFF, 16'd10, 16'd3, 16'd0, 16'd0));
        send_item(make_item(kmtv_pkg::ACT_DECIDE, 3'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0));
        send_item(make_item(kmtv_pkg::ACT_DECIDE, 3'd0, 16'hFFFF, 16'd0, 16'd0, 16'd0, 16'd0));
        send_item(make_item(kmtv_pkg::ACT_LOAD, 3'd0, 16'd0, 16'd5, 16'd1, 16'd1, 16'd0));
        send_item(make_item(kmtv_pkg::ACT_DECIDE, 3'd0, 16'd10, 16'd0, 16'd0, 16'd0, 16'd0));
        for (int b = 4; b < 8; b++)
            send_item(make_item(kmtv_pkg::ACT_ADD_ONE, 3'(b), 16'hFFFF, 16'd0, 16'd0,
                                16'd0, 16'd0));
        for (int b = 0; b < kmtv_pkg::NUM_BASES; b++)
            send_item(make_item(kmtv_pkg::ACT_ADD_ONE, 3'(b), 16'(b + 1) * 16'd100, 16'd0,
                                16'd0, 16'd0, 16'd0));
        send_item(make_item(kmtv_pkg::ACT_DECIDE, 3'd0, 16'd50, 16'd0, 16'd0, 16'd0, 16'd0));
        send_item(make_item(kmtv_pkg::ACT_LOAD, 3'd0, 16'd0, 16'd7, 16'd7, 16'd0, 16'd0));
        send_item(make_item(kmtv_pkg::ACT_DECIDE, 3'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0));
        send_item(make_item(kmtv_pkg::ACT_ADD_FOUR, 3'd0, 16'd0, 16'd0, 16'd0, 16'd9, 16'd9));
        send_item(make_item(kmtv_pkg::ACT_DECIDE, 3'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0));
        send_item(make_item(kmtv_pkg::ACT_LOAD, 3'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0));
        send_item(make_item(kmtv_pkg::ACT_DECIDE, 3'd0, 16'd1000, 16'd0, 16'd0, 16'd0,
                            16'd0));
    endtask

    task automatic test_config_extremes();
        configure(16'd0, 17'd0);
        send_item(make_item(kmtv_pkg::ACT_DECIDE, 3'd0, 16'hFFFF, 16'd0, 16'd0, 16'd0, 16'd0));
        send_item(make_item(kmtv_pkg::ACT_LOAD, 3'd0, 16'd0, 16'd0, 16'd0, 16'd1, 16'd0));
        send_item(make_item(kmtv_pkg::ACT_DECIDE, 3'd0, 16'hFFFF, 16'd0, 16'd0, 16'd0, 16'd0));
        configure(16'hFFFF, 17'h1FFFF);
        send_item(make_item(kmtv_pkg::ACT_LOAD, 3'd0, 16'd0, 16'hFFFF, 16'd0, 16'd0, 16'd0));
        send_item(make_item(kmtv_pkg::ACT_DECIDE, 3'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0));
        send_item(make_item(kmtv_pkg::ACT_DECIDE, 3'd0, 16'hFFFF, 16'd0, 16'd0, 16'd0, 16'd0));
        configure(16'd1, 17'h10000);
        send_item(make_item(kmtv_pkg::ACT_LOAD, 3'd0, 16'd0, 16'd0, 16'd40, 16'd39, 16'd0));
        send_item(make_item(kmtv_pkg::ACT_DECIDE, 3'd0, 16'd40, 16'd0, 16'd0, 16'd0, 16'd0));
        send_item(make_item(kmtv_pkg::ACT_DECIDE, 3'd0, 16'd39, 16'd0, 16'd0, 16'd0, 16'd0));
        send_item(make_item(kmtv_pkg::ACT_DECIDE, 3'd0, 16'd41, 16'd0, 16'd0, 16'd0, 16'd0));
    endtask

    task automatic test_backpressure();
        configure(kmtv_pkg::MIN_DEPTH_FLOOR_RESET, kmtv_pkg::KEEP_FRACTION_RESET);
        hold_off_request = HOLD_OFF_CYCLES;
        repeat (8) send_vote_group();
        wait_for_results();
        repeat (4) send_vote_group();
    endtask

    task automatic test_random_phases();
        kmtv_pkg::field_t min_floor;
        kmtv_pkg::keep_t  keep_fraction;
        for (int phase = 0; phase < 6; phase++) begin
            case ($urandom_range(0, 5))
                0: min_floor = '0;
                1: min_floor = '1;
                2, 3: min_floor = kmtv_pkg::field_t'($urandom_range(0, 31));
                default: min_floor = kmtv_pkg::field_t'($urandom);
            endcase
            case ($urandom_range(0, 5))
                0: keep_fraction = '0;
                1: keep_fraction = 17'h10000;
                2: keep_fraction = '1;
                3: keep_fraction = kmtv_pkg::KEEP_FRACTION_RESET;
                default: keep_fraction = kmtv_pkg::keep_t'($urandom);
            endcase
            configure(min_floor, keep_fraction);
            repeat (28) begin
                if ($urandom_range(0, 6) == 0) send_noise();
                else send_vote_group();
                if ($urandom_range(0, 30) == 0) wait_for_results();
            end
        end
    endtask

    task automatic test_steady_stream();
        settle_block();
        sender_gaps = 1'b0;
        receiver_gaps = 1'b0;
        configure(kmtv_pkg::field_t'($urandom_range(0, 7)), kmtv_pkg::KEEP_FRACTION_RESET);
        repeat (40) send_vote_group();
    endtask

    initial begin
        aresetn <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata <= '0;
        s_tuser <= '0;
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= '0;
        pwdata <= '0;
        for (int i = 0; i < kmtv_pkg::NUM_BASES; i++) tally_model[i] = '0;
        floor_model = kmtv_pkg::MIN_DEPTH_FLOOR_RESET;
        keep_model = kmtv_pkg::KEEP_FRACTION_RESET;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        sender_gaps = 1'b1;
        receiver_gaps = 1'b1;
        test_directed_actions();
        test_config_extremes();
        test_backpressure();
        test_random_phases();
        test_steady_stream();
        wait_for_results();
        repeat (6) @(posedge aclk);
        if (fail_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

    initial begin
        m_tready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (hold_off_request > 0) begin
                m_tready <= 1'b0;
                repeat (hold_off_request) @(posedge aclk);
                hold_off_request = 0;
            end else if (receiver_gaps && $urandom_range(0, 9) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 18)) @(posedge aclk);
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    always @(posedge aclk) begin
        kmtv_pkg::result_t expected;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_results.size() == 0) begin
                $error("result with no item waiting: %h", m_tdata);
                fail_count++;
            end else begin
                expected = pending_results.pop_front();
                if (m_tdata[2:0] !== expected.extension) begin
                    $error("extension: expected %0d, actual %0d",
                           expected.extension, m_tdata[2:0]);
                    fail_count++;
                end
                if (m_tdata[3] !== expected.all_zero) begin
                    $error("all_zero: expected %0b, actual %0b", expected.all_zero, m_tdata[3]);
                    fail_count++;
                end
                for (int i = 0; i < kmtv_pkg::NUM_BASES; i++) begin
                    if (m_tdata[4 + 16*i +: 16] !== expected.tallies[i]) begin
                        $error("tally_%s: expected %0d, actual %0d",
                               (i == 0) ? "a" : (i == 1) ? "c" : (i == 2) ? "g" : "t",
                               expected.tallies[i], m_tdata[4 + 16*i +: 16]);
                        fail_count++;
                    end
                end
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $display("Verification failed");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

endmodule

// ----- kmer_extension_tally_vote_top.f -----
src/kmtv_pkg.sv
src/kmtv_cfg_regs.sv
src/kmtv_tally_update.sv
src/kmtv_decide.sv
src/kmer_extension_tally_vote_top.sv
tb/sv/kmer_extension_tally_vote_top_tb.sv
